[design/sha256_message_hasher_core_macros.svh]
// Assertion helpers for the SHA-256 hasher core.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef SHA256_MESSAGE_HASHER_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASHER_CORE_MACROS_SVH

// Property that must hold at every clock edge.
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sha_mh_pkg.sv]
// ----------------------------------------------------------------------------
// sha_mh_pkg
// Types, constants and round functions shared by the SHA-256 hasher core.
// ----------------------------------------------------------------------------
package sha_mh_pkg;

  localparam int unsigned BufWords = 16;
  localparam int unsigned BufAw    = 4;
  localparam int unsigned Rounds   = 64;

  typedef logic [7:0][31:0] hv_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD1,
    PH_PAD2
  } phase_e;

  // status of the compression engine
  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  localparam hv_t InitHv = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

[design/sha_mh_buf.sv]
// ----------------------------------------------------------------------------
// sha_mh_buf
// 16 x 32-bit block buffer, byte-writable, one registered read port.
// ----------------------------------------------------------------------------
module sha_mh_buf
  import sha_mh_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [BufAw-1:0]  waddr_i,
  input  logic [3:0]        wbe_i,
  input  logic [31:0]       wdata_i,
  input  logic [BufAw-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [BufWords];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (we_i && wbe_i[b]) begin
        mem_q[waddr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/sha_mh_cmp.sv]
// ----------------------------------------------------------------------------
// sha_mh_cmp
// SHA-256 compression engine: one round per cycle, rolling 16-word schedule.
// ----------------------------------------------------------------------------
module sha_mh_cmp
  import sha_mh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hv_t               init_i,
  input  logic [31:0]       rdata_i,
  output logic [BufAw-1:0]  raddr_o,
  output hv_t               wv_o,
  output cmp_stat_t         stat_o
);

  logic [5:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  hv_t         wv_q, wv_d;
  logic [15:0][31:0] win_q, win_d;
  logic [31:0] w, t1, t2;

  // word r arrives from the buffer in round r; fetch the next one now
  assign raddr_o = start_i ? '0 : rnd_q[BufAw-1:0] + 1'b1;

  always_comb begin
    if (rnd_q < 6'd16) begin
      w = rdata_i;
    end else begin
      w = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
    end
    t1 = wv_q[7] + bsig1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
       + RoundK[rnd_q] + w;
    t2 = bsig0(wv_q[0]) + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    wv_d   = wv_q;
    win_d  = win_q;
    if (start_i) begin
      rnd_d  = '0;
      busy_d = 1'b1;
      wv_d   = init_i;
    end else if (busy_q) begin
      win_d = {w, win_q[15:1]};
      wv_d  = {wv_q[6], wv_q[5], wv_q[4], wv_q[3] + t1, wv_q[2], wv_q[1], wv_q[0], t1 + t2};
      rnd_d = rnd_q + 1'b1;
      if (rnd_q == 6'(Rounds - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rnd_q  <= rnd_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q  <= wv_d;
    win_q <= win_d;
  end

  assign wv_o        = wv_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[design/sha256_message_hasher_core.sv]
// Sequence: a byte that does not fill a block is only written to the buffer; a full block
// adds a compression; end of message adds a padding write sweep and a compression,
// both twice when the length spills to a second block, then the 8 digest words go out.
// Input: one item at a time; none is taken while padding, compression or digest output runs.
// Reset: asynchronous, active low; chaining words return to the initial value, counts clear.
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// Byte-serial SHA-256 hasher with padding, length append and raw block mode.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_core_macros.svh"

module sha256_message_hasher_core
  import sha_mh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e      st_q, st_d;
  phase_e      ph_q, ph_d;
  logic        raw_cfg_q;
  logic        raw_q;
  logic        eom_q;
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  hv_t         chain_q;
  logic [3:0]  pad_cnt_q;
  logic [2:0]  emit_cnt_q;
  logic        go_q, go_d;
  logic        ovalid_q;
  logic [31:0] oword_q;
  logic [2:0]  oidx_q;

  logic        acc, full, load;
  logic        we;
  logic [3:0]  waddr, wbe;
  logic [31:0] wdata;
  logic [BufAw-1:0] raddr;
  logic [31:0] rdata;
  hv_t         wv;
  cmp_stat_t   cst;
  logic [63:0] bitlen;

  assign acc    = in_valid_i && !in_stall_o;
  assign full   = byte_valid_i && (fill_q == 6'd63);
  assign load   = (st_q == ST_EMIT) && (!ovalid_q || !out_stall_i);
  assign bitlen = {total_q, 3'b000};

  sha_mh_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wbe_i   (wbe),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sha_mh_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .init_i  (raw_q ? InitHv : chain_q),
    .rdata_i (rdata),
    .raddr_o (raddr),
    .wv_o    (wv),
    .stat_o  (cst)
  );

  // buffer write: one byte per accepted item with a valid byte, or one padding word per cycle
  always_comb begin
    we    = 1'b0;
    waddr = fill_q[5:2];
    wbe   = '0;
    wdata = {4{data_byte_i}};
    if (st_q == ST_IDLE) begin
      we  = acc && byte_valid_i;
      wbe = 4'b1000 >> fill_q[1:0];
    end else if (st_q == ST_PAD) begin
      we    = 1'b1;
      waddr = pad_cnt_q;
      wbe   = 4'b1111;
      wdata = '0;
      if (ph_q == PH_PAD1) begin
        for (int k = 0; k < 4; k++) begin
          if ({pad_cnt_q, 2'(k)} < fill_q) begin
            wbe[3-k] = 1'b0;
          end else if ({pad_cnt_q, 2'(k)} == fill_q) begin
            wdata[(3-k)*8 +: 8] = 8'h80;
          end
        end
      end
      // length goes in the last two words unless it spills to a second block
      if (ph_q == PH_PAD2 || fill_q < 6'd56) begin
        if (pad_cnt_q == 4'd14) begin
          wbe   = 4'b1111;
          wdata = bitlen[63:32];
        end else if (pad_cnt_q == 4'd15) begin
          wbe   = 4'b1111;
          wdata = bitlen[31:0];
        end
      end
    end
  end

  always_comb begin
    st_d       = st_q;
    ph_d       = ph_q;
    go_d       = 1'b0;
    in_stall_o = (st_q != ST_IDLE);
    case (st_q)
      ST_IDLE: begin
        if (acc) begin
          if (full) begin
            st_d = ST_CMP;
            ph_d = PH_DATA;
            go_d = 1'b1;
          end else if (end_of_message_i && !raw_cfg_q) begin
            st_d = ST_PAD;
            ph_d = PH_PAD1;
          end
        end
      end
      ST_PAD: begin
        if (pad_cnt_q == 4'd15) begin
          st_d = ST_CMP;
          go_d = 1'b1;
        end
      end
      ST_CMP: begin
        if (cst.done) begin
          if (raw_q) begin
            st_d = ST_EMIT;
          end else begin
            case (ph_q)
              PH_DATA: begin
                st_d = eom_q ? ST_PAD : ST_IDLE;
                ph_d = PH_PAD1;
              end
              PH_PAD1: begin
                if (fill_q >= 6'd56) begin
                  st_d = ST_PAD;
                  ph_d = PH_PAD2;
                end else begin
                  st_d = ST_EMIT;
                end
              end
              default: st_d = ST_EMIT;
            endcase
          end
        end
      end
      ST_EMIT: begin
        if (load && emit_cnt_q == 3'd7) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ph_q <= PH_DATA;
      go_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      go_q <= go_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_cfg_q  <= 1'b0;
      raw_q      <= 1'b0;
      eom_q      <= 1'b0;
      fill_q     <= '0;
      total_q    <= '0;
      chain_q    <= InitHv;
      pad_cnt_q  <= '0;
      emit_cnt_q <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        raw_cfg_q <= cfg_wdata_i;
      end
      if (st_q == ST_IDLE && acc) begin
        raw_q <= raw_cfg_q;
        eom_q <= end_of_message_i;
        if (raw_cfg_q && end_of_message_i) begin
          fill_q <= '0;
        end else begin
          fill_q <= fill_q + 6'(byte_valid_i);
        end
        if (!raw_cfg_q) begin
          total_q <= total_q + 61'(byte_valid_i);
        end
      end
      if (st_q == ST_PAD) begin
        pad_cnt_q <= pad_cnt_q + 1'b1;
      end else begin
        pad_cnt_q <= '0;
      end
      if (st_q == ST_CMP && cst.done && !raw_q) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + wv[i];
        end
      end
      if (load) begin
        emit_cnt_q <= emit_cnt_q + 1'b1;
        if (emit_cnt_q == 3'd7 && !raw_q) begin
          chain_q <= InitHv;
          fill_q  <= '0;
          total_q <= '0;
        end
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      oword_q <= raw_q ? InitHv[emit_cnt_q] + wv[emit_cnt_q] : chain_q[emit_cnt_q];
      oidx_q  <= emit_cnt_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign digest_word_o = oword_q;
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  `SHA_ASSERT(a_done_in_cmp, !cst.done || st_q == ST_CMP, "compression done outside CMP state")
  `SHA_ASSERT(a_no_accept_busy, !cst.busy || in_stall_o, "input taken during compression")
  `SHA_ASSERT_NEXT(a_raw_keeps_chain, raw_q && st_q == ST_CMP, $stable(chain_q), "raw mode changed chaining value")

endmodule
